@@ rtl/per_bin_record_moving_average_unit_assert.svh @@
// Assertion macros for the per-bin record moving average datapath.
`ifndef PER_BIN_RECORD_MOVING_AVERAGE_UNIT_ASSERT_SVH
`define PER_BIN_RECORD_MOVING_AVERAGE_UNIT_ASSERT_SVH
`ifndef NO_ASSERTIONS
// Condition that must hold at every clock edge out of reset.
`define PBRMA_ASSERT_ALWAYS(lbl, cond) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) \
    else $error("assertion failed");
// Antecedent in one cycle implies consequent in the next.
`define PBRMA_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define PBRMA_ASSERT_ALWAYS(lbl, cond)
`define PBRMA_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

@@ rtl/pbrma_pkg.sv @@
// Types and constants shared by the moving average controller and datapath.
package pbrma_pkg;

  localparam int MaxAverages = 16;
  localparam int SlotW       = 4;
  localparam int MaxRecLen   = 1024;
  localparam int BinW        = 10;
  localparam int LenW        = 11;
  localparam int SampleW     = 16;
  localparam int HeldW       = 5;
  localparam int SumW        = 21;
  localparam int DivW        = 28;
  localparam int DivCntW     = 5;
  localparam int AvgW        = 24;
  localparam int AddrW       = SlotW + BinW;

  typedef enum logic [1:0] {
    OpOpen   = 2'd0,
    OpInsert = 2'd1,
    OpClear  = 2'd2,
    OpNone   = 2'd3
  } op_e;

  localparam logic [1:0] ErrOk    = 2'd0;
  localparam logic [1:0] ErrEmpty = 2'd1;
  localparam logic [1:0] ErrBin   = 2'd2;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic       load;
    logic       open_rec;
    logic       clr_log;
    logic       clr_step;
    logic       wr_sample;
    logic       rd_issue;
    logic       acc;
    logic       div_start;
    logic       div_step;
    logic       out_load;
    logic [1:0] err;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    op_e  op;
    logic held_zero;
    logic bin_bad;
    logic clr_done;
    logic more;
    logic len_match;
    logic div_done;
    logic out_busy;
  } status_t;

endpackage

@@ rtl/pbrma_datapath.sv @@
// Datapath: record memory, record lengths, accumulator, serial divider, output register.
module pbrma_datapath
  import pbrma_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  cmd_t                 cmd_i,
  output status_t              status_o,
  input  logic [1:0]           op_i,
  input  logic [LenW-1:0]      size_i,
  input  logic [BinW-1:0]      bin_i,
  input  logic [SampleW-1:0]   sample_i,
  input  logic                 cfg_we_i,
  input  logic [HeldW-1:0]     cfg_data_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [AvgW-1:0]      average_o,
  output logic [HeldW-1:0]     records_used_o,
  output logic [1:0]           error_code_o
);

  logic [SampleW-1:0] mem [MaxAverages*MaxRecLen];
  logic [LenW-1:0]    lengths_q [MaxAverages];

  logic [SlotW-1:0]   slot_q, slot_d;
  logic [HeldW-1:0]   held_q, held_d;
  logic [HeldW-1:0]   nof_q;
  logic [HeldW-1:0]   lim;
  logic               out_valid_q;
  logic [DivCntW-1:0] div_cnt_q;

  op_e                op_q;
  logic [LenW-1:0]    size_q, clr_len_q, nlen_q, sat_len;
  logic [BinW-1:0]    bin_q;
  logic [SampleW-1:0] samp_q, rdata_q;
  logic [LenW-1:0]    clr_cnt_q;
  logic [HeldW-1:0]   used_q;
  logic               match_q, neg_q;
  logic signed [SumW-1:0] sum_q, abs_sum;
  logic [DivW-1:0]    quo_q;
  logic [HeldW-1:0]   rem_q;
  logic [HeldW:0]     rem_n;
  logic [SlotW-1:0]   rd_slot, len_addr;
  logic [LenW-1:0]    len_rd;

  logic               we;
  logic [AddrW-1:0]   waddr;
  logic [SampleW-1:0] wdata;

  // Effective record limit: zero counts as one, anything above the log depth saturates.
  always_comb begin
    if (nof_q == '0) begin
      lim = HeldW'(1);
    end else if (nof_q > HeldW'(MaxAverages)) begin
      lim = HeldW'(MaxAverages);
    end else begin
      lim = nof_q;
    end
  end

  assign sat_len  = (size_q > LenW'(MaxRecLen)) ? LenW'(MaxRecLen) : size_q;
  assign rd_slot  = slot_q + used_q[SlotW-1:0];
  assign len_addr = cmd_i.rd_issue ? rd_slot : slot_q;
  assign len_rd   = lengths_q[len_addr];
  assign abs_sum  = sum_q[SumW-1] ? -sum_q : sum_q;
  assign rem_n    = {rem_q, quo_q[DivW-1]};

  // Log bookkeeping on open and clear; configuration writes are handled in the control registers.
  always_comb begin
    slot_d = slot_q;
    held_d = held_q;
    if (cmd_i.open_rec) begin
      slot_d = slot_q - SlotW'(1);
      held_d = (held_q >= lim) ? lim : held_q + HeldW'(1);
    end else if (cmd_i.clr_log) begin
      held_d = '0;
    end
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_q      <= '0;
      held_q      <= '0;
      nof_q       <= HeldW'(1);
      out_valid_q <= 1'b0;
      div_cnt_q   <= '0;
    end else begin
      slot_q <= slot_d;
      if (cfg_we_i) begin
        nof_q <= cfg_data_i;
        if (held_q > ((cfg_data_i == '0) ? HeldW'(1) :
                      (cfg_data_i > HeldW'(MaxAverages)) ? HeldW'(MaxAverages) :
                      cfg_data_i)) begin
          held_q <= (cfg_data_i == '0) ? HeldW'(1) :
                    (cfg_data_i > HeldW'(MaxAverages)) ? HeldW'(MaxAverages) : cfg_data_i;
        end
      end else begin
        held_q <= held_d;
      end
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (cmd_i.div_start) begin
        div_cnt_q <= '0;
      end else if (cmd_i.div_step) begin
        div_cnt_q <= div_cnt_q + DivCntW'(1);
      end
    end
  end

  // Item capture, record lengths, accumulation and division.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q   <= op_e'(op_i);
      size_q <= size_i;
      bin_q  <= bin_i;
      samp_q <= sample_i;
    end
    if (cmd_i.open_rec) begin
      lengths_q[slot_d] <= sat_len;
      clr_len_q         <= sat_len;
      clr_cnt_q         <= '0;
    end
    if (cmd_i.clr_step) begin
      clr_cnt_q <= clr_cnt_q + LenW'(1);
    end
    if (cmd_i.wr_sample) begin
      nlen_q <= len_rd;
      sum_q  <= SumW'(signed'(samp_q));
      used_q <= HeldW'(1);
    end
    if (cmd_i.rd_issue) begin
      match_q <= (len_rd == nlen_q);
    end
    if (cmd_i.acc) begin
      sum_q  <= sum_q + SumW'(signed'(rdata_q));
      used_q <= used_q + HeldW'(1);
    end
    if (cmd_i.div_start) begin
      neg_q <= sum_q[SumW-1];
      quo_q <= {abs_sum[DivW-9:0], 8'd0};
      rem_q <= '0;
    end else if (cmd_i.div_step) begin
      if (rem_n >= {1'b0, used_q}) begin
        rem_q <= HeldW'(rem_n - {1'b0, used_q});
        quo_q <= {quo_q[DivW-2:0], 1'b1};
      end else begin
        rem_q <= rem_n[HeldW-1:0];
        quo_q <= {quo_q[DivW-2:0], 1'b0};
      end
    end
    if (cmd_i.out_load) begin
      error_code_o <= cmd_i.err;
      if (cmd_i.err != ErrOk) begin
        average_o      <= '0;
        records_used_o <= '0;
      end else begin
        average_o      <= neg_q ? -quo_q[AvgW-1:0] : quo_q[AvgW-1:0];
        records_used_o <= used_q;
      end
    end
  end

  // Record memory: one write port, one registered read port.
  always_comb begin
    we    = cmd_i.clr_step | cmd_i.wr_sample;
    waddr = cmd_i.clr_step ? {slot_q, clr_cnt_q[BinW-1:0]} : {slot_q, bin_q};
    wdata = cmd_i.clr_step ? '0 : samp_q;
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.rd_issue) begin
      rdata_q <= mem[{rd_slot, bin_q}];
    end
  end

  // Status back to the controller.
  always_comb begin
    status_o.op        = op_q;
    status_o.held_zero = (held_q == '0);
    status_o.bin_bad   = ({1'b0, bin_q} >= lengths_q[slot_q]);
    status_o.clr_done  = (clr_cnt_q == clr_len_q);
    status_o.more      = (used_q < held_q);
    status_o.len_match = match_q;
    status_o.div_done  = (div_cnt_q == DivCntW'(DivW));
    status_o.out_busy  = out_valid_q & ~out_ready_i;
  end

  assign out_valid_o = out_valid_q;

`include "per_bin_record_moving_average_unit_assert.svh"

  `PBRMA_ASSERT_ALWAYS(a_held_bound, held_q <= HeldW'(MaxAverages))
  `PBRMA_ASSERT_ALWAYS(a_read_in_log, !cmd_i.rd_issue || (used_q < held_q))
  `PBRMA_ASSERT_NEXT(a_out_hold, out_valid_q && !out_ready_i, out_valid_q)

endmodule

@@ rtl/pbrma_ctrl.sv @@
// Controller: sequences record opening, clearing sweep, averaging walk and division.
module pbrma_ctrl
  import pbrma_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_ready_o,
  input  status_t status_i,
  output cmd_t    cmd_o
);

  typedef enum logic [3:0] {
    StIdle,
    StDispatch,
    StClear,
    StWrite,
    StLoop,
    StAcc,
    StDivide,
    StEmit
  } state_e;

  state_e     state_q, state_d;
  logic [1:0] err_q, err_d;

  // Next state and commands.
  always_comb begin
    state_d = state_q;
    err_d   = err_q;
    cmd_o   = '0;
    cmd_o.err = err_q;
    unique case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = StDispatch;
        end
      end
      StDispatch: begin
        unique case (status_i.op)
          OpOpen: begin
            cmd_o.open_rec = 1'b1;
            state_d        = StClear;
          end
          OpClear: begin
            cmd_o.clr_log = 1'b1;
            state_d       = StIdle;
          end
          OpInsert: begin
            if (status_i.held_zero) begin
              err_d   = ErrEmpty;
              state_d = StEmit;
            end else if (status_i.bin_bad) begin
              err_d   = ErrBin;
              state_d = StEmit;
            end else begin
              err_d   = ErrOk;
              state_d = StWrite;
            end
          end
          OpNone: state_d = StIdle;
          default: state_d = StIdle;
        endcase
      end
      StClear: begin
        if (status_i.clr_done) begin
          state_d = StIdle;
        end else begin
          cmd_o.clr_step = 1'b1;
        end
      end
      StWrite: begin
        cmd_o.wr_sample = 1'b1;
        state_d         = StLoop;
      end
      StLoop: begin
        if (status_i.more) begin
          cmd_o.rd_issue = 1'b1;
          state_d        = StAcc;
        end else begin
          cmd_o.div_start = 1'b1;
          state_d         = StDivide;
        end
      end
      StAcc: begin
        if (status_i.len_match) begin
          cmd_o.acc = 1'b1;
          state_d   = StLoop;
        end else begin
          cmd_o.div_start = 1'b1;
          state_d         = StDivide;
        end
      end
      StDivide: begin
        if (status_i.div_done) begin
          state_d = StEmit;
        end else begin
          cmd_o.div_step = 1'b1;
        end
      end
      StEmit: begin
        if (!status_i.out_busy) begin
          cmd_o.out_load = 1'b1;
          state_d        = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      err_q   <= ErrOk;
    end else begin
      state_q <= state_d;
      err_q   <= err_d;
    end
  end

  assign in_ready_o = (state_q == StIdle);

endmodule

@@ rtl/per_bin_record_moving_average_unit.sv @@
// Top level of the per-bin record moving average unit.
// The slave stream carries one command per beat: tuser selects open record,
// insert sample or clear log; tdata carries record size, bin index and sample.
// Opening a record sweeps the new row to zero, one bin per cycle. An insert
// writes the sample, then walks the older records one at a time through the
// record memory's single read port, and divides by the record count with a
// bit-serial divider; the walk stops early at a record of another size.
// Failed inserts skip the walk and the divide; clear and ignored commands
// give no result. One item is worked on at a time.
// Only an insert gives a master beat: the mean in Q.8 and the record count in
// tdata, the error code in tuser. The result waits in an output register; a
// stalled receiver holds the block in its final step, and no new beat is taken
// until the result is loaded. The configuration channel writes the number of
// records averaged and is always ready. After reset the log is empty and the
// record limit is one.
module per_bin_record_moving_average_unit
  import pbrma_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // tdata: record_size [10:0], bin_index [20:11], sample [36:21], zero fill.
  input  logic [39:0] s_axis_tdata_i,
  // tuser: operation [1:0].
  input  logic [1:0]  s_axis_tuser_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // tdata: average [23:0], records_used [28:24], zero fill.
  output logic [31:0] m_axis_tdata_o,
  // tuser: error_code [1:0].
  output logic [1:0]  m_axis_tuser_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [4:0]  cfg_data_i
);

  cmd_t               cmd;
  status_t            status;
  logic [AvgW-1:0]    average;
  logic [HeldW-1:0]   records_used;

  pbrma_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  pbrma_datapath u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .status_o       (status),
    .op_i           (s_axis_tuser_i),
    .size_i         (s_axis_tdata_i[10:0]),
    .bin_i          (s_axis_tdata_i[20:11]),
    .sample_i       (s_axis_tdata_i[36:21]),
    .cfg_we_i       (cfg_valid_i),
    .cfg_data_i     (cfg_data_i),
    .out_valid_o    (m_axis_tvalid_o),
    .out_ready_i    (m_axis_tready_i),
    .average_o      (average),
    .records_used_o (records_used),
    .error_code_o   (m_axis_tuser_o)
  );

  assign cfg_ready_o    = 1'b1;
  assign m_axis_tdata_o = {3'b000, records_used, average};

endmodule

@@ sim/testbench.sv @@
// Self-checking testbench for the per-bin record moving average unit.
module testbench;
  import pbrma_pkg::*;

  // Scoreboard: holds its own copy of the record log and the queue of expected means.
  class mean_scoreboard;
    logic signed [15:0] rows [16][1024];
    int unsigned        row_len [16];
    int unsigned        newest;
    int unsigned        held;
    int unsigned        limit_reg;
    logic [31:0]        exp_data [$];
    logic [1:0]         exp_err [$];
    int                 errors;

    function void clear_state();
      newest = 0;
      held = 0;
      limit_reg = 1;
      errors = 0;
    endfunction

    function int unsigned limit();
      if (limit_reg < 1) return 1;
      if (limit_reg > 16) return 16;
      return limit_reg;
    endfunction

    function void note_config(logic [4:0] v);
      limit_reg = v;
      if (held > limit()) held = limit();
    endfunction

    // Append one expected result beat at the tail of the queues.
    function void add_expect(logic [31:0] d, logic [1:0] e);
      exp_data = {exp_data, d};
      exp_err  = {exp_err, e};
    endfunction

    // Work out the effect of one accepted command beat.
    function void note_command(op_e op, logic [10:0] size, logic [9:0] bin,
                               logic signed [15:0] smp);
      longint sum;
      longint mean;
      int unsigned used;
      int unsigned s;
      int unsigned len;
      if (op == OpOpen) begin
        len = (size > 1024) ? 1024 : size;
        if (held >= limit()) held = limit() - 1;
        newest = (newest + 15) % 16;
        for (int i = 0; i < 1024; i++) rows[newest][i] = '0;
        row_len[newest] = len;
        held++;
      end else if (op == OpClear) begin
        held = 0;
      end else if (op == OpInsert) begin
        if (held == 0) begin
          add_expect('0, ErrEmpty);
        end else if (bin >= row_len[newest]) begin
          add_expect('0, ErrBin);
        end else begin
          rows[newest][bin] = smp;
          len = row_len[newest];
          sum = smp;
          used = 1;
          while (used < held) begin
            s = (newest + used) % 16;
            if (row_len[s] != len) break;
            sum += rows[s][bin];
            used++;
          end
          mean = (sum * 256) / longint'(used);
          add_expect({3'b000, used[4:0], mean[23:0]}, ErrOk);
        end
      end
    endfunction

    // Compare one result beat with the oldest expectation.
    function void check_result(logic [31:0] data, logic [1:0] err);
      logic [31:0] ed;
      logic [1:0]  ee;
      if (exp_data.size() == 0) begin
        $display("%0t: unexpected result data=%h err=%0d", $time, data, err);
        errors++;
        return;
      end
      ed = exp_data.pop_front();
      ee = exp_err.pop_front();
      if (data[23:0] !== ed[23:0]) begin
        $display("%0t: average expected %h actual %h", $time, ed[23:0], data[23:0]);
        errors++;
      end
      if (data[28:24] !== ed[28:24]) begin
        $display("%0t: records used expected %0d actual %0d", $time, ed[28:24],
                 data[28:24]);
        errors++;
      end
      if (data[31:29] !== 3'b000) begin
        $display("%0t: fill bits expected 0 actual %b", $time, data[31:29]);
        errors++;
      end
      if (err !== ee) begin
        $display("%0t: error code expected %0d actual %0d", $time, ee, err);
        errors++;
      end
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid_i = 1'b0;
  logic        s_axis_tready_o;
  logic [39:0] s_axis_tdata_i = '0;
  logic [1:0]  s_axis_tuser_i = '0;
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;
  logic [31:0] m_axis_tdata_o;
  logic [1:0]  m_axis_tuser_o;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [4:0]  cfg_data_i = '0;

  mean_scoreboard sb;
  bit  quiet_phase = 0;
  bit  hold_sink = 0;
  bit  hold_go = 0;

  always #5 clk_i = ~clk_i;

  per_bin_record_moving_average_unit dut (.*);

  // Send one command beat, at times with a random gap beforehand. Valid stays high on
  // return; the caller drops it when no further beat follows straight away.
  task automatic send_command(op_e op, logic [10:0] size, logic [9:0] bin,
                              logic [15:0] smp);
    if (!quiet_phase && $urandom_range(3) == 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat ($urandom_range(1, 5)) @(negedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tuser_i  <= op;
    s_axis_tdata_i  <= {3'b000, smp, bin, size};
    do @(posedge clk_i); while (!s_axis_tready_o);
    sb.note_command(op, size, bin, smp);
    @(negedge clk_i);
  endtask

  // Wait until every result is in, let the block settle, then write the limit.
  task automatic write_limit(logic [4:0] v);
    s_axis_tvalid_i <= 1'b0;
    while (sb.exp_data.size() != 0) @(negedge clk_i);
    repeat (1100) @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.note_config(v);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // A random command, mostly short records of a shared size so averages go deep.
  task automatic random_command(int unsigned rec_size);
    int unsigned pick;
    logic [10:0] sz;
    pick = $urandom_range(99);
    sz = ($urandom_range(7) == 0) ? 11'($urandom_range(0, 2047)) : 11'(rec_size);
    if ($urandom_range(40) == 0) sz = 11'($urandom_range(1000, 1024));
    if (pick < 12)
      send_command(OpOpen, sz, 10'($urandom), 16'($urandom));
    else if (pick < 14)
      send_command(OpClear, 11'($urandom), 10'($urandom), 16'($urandom));
    else if (pick < 16)
      send_command(OpNone, 11'($urandom), 10'($urandom), 16'($urandom));
    else if (pick < 22)
      send_command(OpInsert, 11'($urandom), 10'($urandom), 16'($urandom));
    else
      send_command(OpInsert, 11'($urandom), 10'($urandom_range(0, rec_size)),
                   16'($urandom));
  endtask

  // Result side: random stalls, one long hold-off, and the check of each beat.
  initial begin
    forever begin
      @(negedge clk_i);
      if (hold_sink) m_axis_tready_i <= 1'b0;
      else if (!quiet_phase && $urandom_range(4) == 0) begin
        m_axis_tready_i <= 1'b0;
        repeat ($urandom_range(1, 4)) @(negedge clk_i);
        m_axis_tready_i <= 1'b1;
      end else m_axis_tready_i <= 1'b1;
    end
  end

  always @(posedge clk_i)
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i)
      sb.check_result(m_axis_tdata_o, m_axis_tuser_o);

  // Long receiver hold-off while the sender keeps offering beats.
  initial begin
    wait (hold_go && rst_ni);
    repeat (50) @(negedge clk_i);
    hold_sink = 1;
    repeat (600) @(negedge clk_i);
    hold_sink = 0;
  end

  // Main stimulus.
  initial begin
    sb = new();
    sb.clear_state();
    repeat (12) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed part: empty log, zero size, extreme sizes, bins and samples.
    send_command(OpInsert, 11'd5, 10'd0, 16'h1234);
    send_command(OpOpen, 11'd0, 10'd0, 16'd0);
    send_command(OpInsert, 11'd0, 10'd0, 16'h7fff);
    send_command(OpOpen, 11'h7ff, 10'h3ff, 16'hffff);
    send_command(OpInsert, 11'd0, 10'h3ff, 16'h8000);
    send_command(OpInsert, 11'h7ff, 10'd0, 16'h7fff);
    send_command(OpNone, 11'h7ff, 10'h3ff, 16'hffff);
    write_limit(5'd16);
    for (int i = 0; i < 5; i++) send_command(OpOpen, 11'd4, 10'd0, 16'd0);
    send_command(OpInsert, 11'd0, 10'd3, 16'h8000);
    send_command(OpInsert, 11'd0, 10'd4, 16'h0001);
    send_command(OpOpen, 11'd3, 10'd0, 16'd0);
    send_command(OpInsert, 11'd0, 10'd2, 16'hfffd);
    send_command(OpClear, 11'd0, 10'd0, 16'd0);
    send_command(OpInsert, 11'd0, 10'd0, 16'd7);
    write_limit(5'd0);
    send_command(OpOpen, 11'd1024, 10'd0, 16'd0);
    send_command(OpInsert, 11'd0, 10'h3ff, 16'h8001);
    write_limit(5'd31);
    for (int i = 0; i < 17; i++) send_command(OpOpen, 11'd2, 10'd0, 16'd0);
    send_command(OpInsert, 11'd0, 10'd1, 16'h8000);

    // Random phases across several limits, including lowering below the held count.
    for (int ph = 0; ph < 6; ph++) begin
      int unsigned rs;
      rs = $urandom_range(1, 12);
      if (ph == 2) write_limit(5'd3);
      else if (ph == 4) write_limit(5'd16);
      else write_limit(5'($urandom));
      if (ph == 1) hold_go = 1;
      if (ph == 5) quiet_phase = 1;
      for (int i = 0; i < 90; i++) random_command(rs);
    end
    s_axis_tvalid_i <= 1'b0;

    while (sb.exp_data.size() != 0) @(negedge clk_i);
    repeat (200) @(negedge clk_i);
    if (sb.errors == 0)
      $display("per_bin_record_moving_average_unit regression: pass");
    else
      $display("per_bin_record_moving_average_unit regression: fail");
    $finish;
  end

  // Run limit.
  initial begin
    #20000000;
    $display("per_bin_record_moving_average_unit regression: fail");
    $finish;
  end

endmodule

@@ files.f @@
+incdir+rtl
rtl/pbrma_pkg.sv
rtl/pbrma_datapath.sv
rtl/pbrma_ctrl.sv
rtl/per_bin_record_moving_average_unit.sv
sim/testbench.sv
